// ===== rtl/imc_pkg.sv =====
package imc_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ANGLE_FRACTION_BITS = 16;
  localparam int TABLE_FRAC = 24;
  localparam int TABLE_LEN = 24;
  localparam int NSTEPS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
  localparam int ASH = TABLE_FRAC - ANGLE_FRACTION_BITS;

  // gyro magnitude, product, dividend
  localparam int GW = 17;
  localparam int QW = GW + 24 + 5;
  localparam int PROPW = QW + 2;
  localparam int AW = PROPW + 18;
  localparam int CW = 34;

  // chunked reciprocal divide: chunk width, chunk count, dividend width, chunk dividend
  localparam int DCW = 12;
  localparam int DCH = (QW - ASH + DCW - 1) / DCW;
  localparam int NDW = DCH * DCW;
  localparam int DDW = 11 + DCW;

  localparam logic [2:0] REG_GYRO_RANGE    = 3'd0;
  localparam logic [2:0] REG_GYRO_OFFSET_X = 3'd1;
  localparam logic [2:0] REG_GYRO_OFFSET_Y = 3'd2;
  localparam logic [2:0] REG_GYRO_OFFSET_Z = 3'd3;
  localparam logic [2:0] REG_BLEND_WEIGHT  = 3'd4;
  localparam logic [2:0] REG_SAMPLE_PERIOD = 3'd5;

  function automatic logic [10:0] sens_x10(input logic [1:0] r);
    case (r)
      2'd0: sens_x10 = 11'd1310;
      2'd1: sens_x10 = 11'd655;
      2'd2: sens_x10 = 11'd328;
      default: sens_x10 = 11'd164;
    endcase
  endfunction

  // ceil(2^35 / sens_x10), exact for chunk dividends below 2^24
  function automatic logic [27:0] rcp_q35(input logic [1:0] r);
    case (r)
      2'd0: rcp_q35 = 28'd26228808;
      2'd1: rcp_q35 = 28'd52457616;
      2'd2: rcp_q35 = 28'd104755300;
      default: rcp_q35 = 28'd209510600;
    endcase
  endfunction

  function automatic logic [31:0] atan_q24(input logic [4:0] i);
    case (i)
      5'd0: atan_q24 = 32'd754974720;
      5'd1: atan_q24 = 32'd445687602;
      5'd2: atan_q24 = 32'd235489088;
      5'd3: atan_q24 = 32'd119537938;
      5'd4: atan_q24 = 32'd60000934;
      5'd5: atan_q24 = 32'd30029717;
      5'd6: atan_q24 = 32'd15018523;
      5'd7: atan_q24 = 32'd7509720;
      5'd8: atan_q24 = 32'd3754917;
      5'd9: atan_q24 = 32'd1877466;
      5'd10: atan_q24 = 32'd938734;
      5'd11: atan_q24 = 32'd469367;
      5'd12: atan_q24 = 32'd234684;
      5'd13: atan_q24 = 32'd117342;
      5'd14: atan_q24 = 32'd58671;
      5'd15: atan_q24 = 32'd29335;
      5'd16: atan_q24 = 32'd14668;
      5'd17: atan_q24 = 32'd7334;
      5'd18: atan_q24 = 32'd3667;
      5'd19: atan_q24 = 32'd1833;
      5'd20: atan_q24 = 32'd917;
      5'd21: atan_q24 = 32'd458;
      5'd22: atan_q24 = 32'd229;
      5'd23: atan_q24 = 32'd115;
      default: atan_q24 = 32'd0;
    endcase
  endfunction

endpackage

// ===== rtl/imu_complementary_attitude.sv =====
// Complementary-filter attitude estimator. One six-axis sample is taken per beat on the
// input channel and one roll/pitch/yaw beat (signed degrees, ANGLE_FRACTION_BITS fraction
// bits) comes back for it. The block works on one sample at a time and is not ready while
// busy; it is ready again as its result beat is presented. The work per sample is the
// chunked reciprocal divide that turns each gyro rate into an angle increment (DCH chunks
// per axis, each an estimate state and a remainder state), the shared CORDIC rotator
// (NSTEPS steps per angle) and the 17-step shift-add blend; the last state also waits
// while the previous result beat is still pending. Registers are to be written through
// cfg_we/cfg_index/cfg_data only while the block is idle; the block does not enforce it.
module imu_complementary_attitude import imc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  input  logic signed [15:0] gyro_x,
  input  logic signed [15:0] gyro_y,
  input  logic signed [15:0] gyro_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] roll_deg,
  output logic signed [31:0] pitch_deg,
  output logic signed [31:0] yaw_deg,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_GMUL  = 4'd1;
  localparam logic [3:0] S_GDIV  = 4'd2;
  localparam logic [3:0] S_CINIT = 4'd3;
  localparam logic [3:0] S_CITER = 4'd4;
  localparam logic [3:0] S_BINIT = 4'd5;
  localparam logic [3:0] S_BITER = 4'd6;
  localparam logic [3:0] S_YAW   = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;
  localparam logic [3:0] S_GREM  = 4'd9;

  localparam logic signed [CW-1:0] ZRND = (ASH == 0) ? CW'(0) : CW'(1) <<< ((ASH > 0) ? ASH - 1 : 0);
  localparam logic signed [CW-1:0] Z90 = CW'(90) <<< TABLE_FRAC;

  logic [1:0]  gyro_range;
  logic signed [15:0] gyro_offset_x, gyro_offset_y, gyro_offset_z;
  logic [15:0] blend_weight;
  logic [23:0] sample_period;

  logic signed [31:0] roll_angle, pitch_angle, yaw_angle;

  logic [3:0] state;
  logic [1:0] axis;
  logic       pass;
  logic [5:0] cnt;

  logic signed [15:0] ax, ay, az;
  logic signed [GW-1:0] g [3];
  logic signed [QW:0]   d [3];
  logic signed [CW-1:0] acc_ang [2];

  logic [NDW-1:0] num, qacc;
  logic [10:0]    rm;
  logic [DDW-1:0] dd;
  logic [DCW-1:0] qd;
  logic signed [CW-1:0] cx, cy, cz;
  logic signed [PROPW-1:0] prop;
  logic signed [CW-1:0] bang;
  logic signed [AW-1:0] accum;

  // gyro product and reciprocal divide step
  logic [GW-1:0] mag;
  logic [GW+23:0] prod;
  logic [QW-1:0] den_sel, qinit;
  logic [10:0] sens;
  logic [DDW-1:0] dchunk, rfull;
  logic [50:0] dm;
  logic [NDW-1:0] qfull;

  always_comb begin
    mag = g[axis][GW-1] ? GW'(-g[axis]) : GW'(g[axis]);
    prod = mag * sample_period;
    sens = sens_x10(gyro_range);
    den_sel = QW'(sens) << ASH;
    qinit = (QW'(prod) << 3) + (QW'(prod) << 1) + (den_sel >> 1);
    dchunk = {rm, num[NDW-1 -: DCW]};
    dm = dchunk * rcp_q35(gyro_range);
    rfull = dd - DDW'(qd) * DDW'(sens);
    qfull = {qacc[NDW-DCW-1:0], qd};
  end

  // cordic rotator
  logic signed [CW-1:0] xs, ys, tab;
  logic signed [CW-1:0] cx0, cy0, cz0, a0, z_round;
  always_comb begin
    xs = cx >>> cnt[4:0];
    ys = cy >>> cnt[4:0];
    tab = CW'(atan_q24(cnt[4:0]));
    a0 = pass ? (CW'(ax) <<< 14) : (CW'(ay) <<< 14);
    cx0 = CW'(az) <<< 14;
    cy0 = a0;
    cz0 = '0;
    if (az < 0) begin
      if (a0 >= 0) begin
        cx0 = a0;
        cy0 = -(CW'(az) <<< 14);
        cz0 = Z90;
      end else begin
        cx0 = -a0;
        cy0 = CW'(az) <<< 14;
        cz0 = -Z90;
      end
    end
    z_round = (cz + ZRND) >>> ASH;
  end

  // blend and saturation
  logic [16:0] wt, wc;
  logic signed [AW-1:0] term_a, term_b, bsh;
  logic signed [PROPW-1:0] ysum;
  logic signed [31:0] bsat, ysat;
  always_comb begin
    wt = {1'b0, blend_weight};
    wc = 17'h10000 - wt;
    term_a = wt[cnt[4:0]] ? (AW'(prop) <<< cnt[4:0]) : '0;
    term_b = wc[cnt[4:0]] ? (AW'(bang) <<< cnt[4:0]) : '0;
    bsh = accum >>> 16;
    if (&bsh[AW-1:31] || ~|bsh[AW-1:31]) begin
      bsat = bsh[31:0];
    end else begin
      bsat = bsh[AW-1] ? 32'sh80000000 : 32'sh7fffffff;
    end
    ysum = PROPW'(yaw_angle) + PROPW'(d[2]);
    if (&ysum[PROPW-1:31] || ~|ysum[PROPW-1:31]) begin
      ysat = ysum[31:0];
    end else begin
      ysat = ysum[PROPW-1] ? 32'sh80000000 : 32'sh7fffffff;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      gyro_range <= '0;
      gyro_offset_x <= '0;
      gyro_offset_y <= '0;
      gyro_offset_z <= '0;
      blend_weight <= 16'd64225;
      sample_period <= 24'd67109;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GYRO_RANGE: gyro_range <= cfg_data[1:0];
        REG_GYRO_OFFSET_X: gyro_offset_x <= cfg_data[15:0];
        REG_GYRO_OFFSET_Y: gyro_offset_y <= cfg_data[15:0];
        REG_GYRO_OFFSET_Z: gyro_offset_z <= cfg_data[15:0];
        REG_BLEND_WEIGHT: blend_weight <= cfg_data[15:0];
        REG_SAMPLE_PERIOD: sample_period <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      roll_angle <= '0;
      pitch_angle <= '0;
      yaw_angle <= '0;
      axis <= '0;
      pass <= 1'b0;
      cnt <= '0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            ax <= accel_x;
            ay <= accel_y;
            az <= accel_z;
            g[0] <= GW'(gyro_x) - GW'(gyro_offset_x);
            g[1] <= GW'(gyro_y) - GW'(gyro_offset_y);
            g[2] <= GW'(gyro_z) - GW'(gyro_offset_z);
            axis <= '0;
            state <= S_GMUL;
          end
        end
        S_GMUL: begin
          num <= NDW'(qinit >> ASH);
          qacc <= '0;
          rm <= '0;
          cnt <= '0;
          state <= S_GDIV;
        end
        S_GDIV: begin
          dd <= dchunk;
          qd <= dm[34+DCW:35];
          state <= S_GREM;
        end
        S_GREM: begin
          rm <= rfull[10:0];
          qacc <= qfull;
          num <= num << DCW;
          if (cnt == 6'(DCH - 1)) begin
            d[axis] <= g[axis][GW-1] ? -$signed({1'b0, QW'(qfull)})
                                     : $signed({1'b0, QW'(qfull)});
            if (axis == 2'd2) begin
              pass <= 1'b0;
              state <= S_CINIT;
            end else begin
              axis <= axis + 2'd1;
              state <= S_GMUL;
            end
          end else begin
            state <= S_GDIV;
          end
          cnt <= cnt + 6'd1;
        end
        S_CINIT: begin
          cx <= cx0;
          cy <= cy0;
          cz <= cz0;
          cnt <= '0;
          state <= S_CITER;
        end
        S_CITER: begin
          if (cnt == 6'(NSTEPS)) begin
            acc_ang[pass] <= ((az == 0) && (a0 == 0)) ? '0 : z_round;
            pass <= ~pass;
            state <= pass ? S_BINIT : S_CINIT;
          end else if (cy >= 0) begin
            cx <= cx + ys;
            cy <= cy - xs;
            cz <= cz + tab;
          end else begin
            cx <= cx - ys;
            cy <= cy + xs;
            cz <= cz - tab;
          end
          cnt <= cnt + 6'd1;
        end
        S_BINIT: begin
          prop <= pass ? PROPW'(pitch_angle) + PROPW'(d[0])
                       : PROPW'(roll_angle) - PROPW'(d[1]);
          bang <= pass ? acc_ang[0] : acc_ang[1];
          accum <= AW'(32768);
          cnt <= '0;
          state <= S_BITER;
        end
        S_BITER: begin
          if (cnt == 6'd17) begin
            if (pass) pitch_angle <= bsat;
            else roll_angle <= bsat;
            pass <= ~pass;
            state <= pass ? S_YAW : S_BINIT;
          end else begin
            accum <= accum + term_a + term_b;
          end
          cnt <= cnt + 6'd1;
        end
        S_YAW: begin
          yaw_angle <= ysat;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            roll_deg <= roll_angle;
            pitch_deg <= pitch_angle;
            yaw_deg <= yaw_angle;
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  import imc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] REG_UNUSED_LO = 3'd6;
  localparam logic [2:0] REG_UNUSED_HI = 3'd7;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_ITEMS = 122;

  localparam longint ATAN_Q24 [24] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367,
    234684, 117342, 58671, 29335, 14668, 7334,
    3667, 1833, 917, 458, 229, 115};
  localparam longint SENS_X10 [4] = '{1310, 655, 328, 164};

  typedef struct packed {
    logic signed [15:0] ax, ay, az, gx, gy, gz;
  } imu_sample_t;

  typedef struct packed {
    logic signed [31:0] roll, pitch, yaw;
  } attitude_t;

  typedef struct packed {
    logic        is_cfg;
    logic [2:0]  idx;
    logic [23:0] data;
    imu_sample_t s;
    logic        chk;
    attitude_t   want;
  } step_row_t;

  localparam imu_sample_t ZS = '0;
  localparam attitude_t ZA = '0;

  localparam step_row_t DIR_TAB [30] = '{
    '{1'b0, 3'd0, 24'd0, ZS, 1'b1, ZA},
    '{1'b0, 3'd0, 24'd0, '{16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0}, 1'b0, ZA},
    '{1'b0, 3'd0, 24'd0, '{16'sd100, 16'sd0, -16'sd200, 16'sd0, 16'sd0, 16'sd0}, 1'b0, ZA},
    '{1'b0, 3'd0, 24'd0, '{-16'sd100, -16'sd7, -16'sd200, 16'sd0, 16'sd0, 16'sd0}, 1'b0, ZA},
    '{1'b0, 3'd0, 24'd0, '{16'sd0, 16'sd32767, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, ZA},
    '{1'b0, 3'd0, 24'd0, '{16'sd0, -16'sd32768, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, ZA},
    '{1'b0, 3'd0, 24'd0, '{16'h8000, 16'h8000, 16'h8000, 16'sd0, 16'sd0, 16'sd0}, 1'b0, ZA},
    '{1'b0, 3'd0, 24'd0, '{16'h7fff, 16'h7fff, 16'h7fff, 16'sd0, 16'sd0, 16'sd0}, 1'b0, ZA},
    '{1'b0, 3'd0, 24'd0, '{16'sd0, 16'sd0, 16'sd0, 16'h7fff, 16'h7fff, 16'h7fff}, 1'b0, ZA},
    '{1'b0, 3'd0, 24'd0, '{16'sd0, 16'sd0, 16'sd0, 16'h8000, 16'h8000, 16'h8000}, 1'b0, ZA},
    '{1'b1, REG_SAMPLE_PERIOD, 24'd0, ZS, 1'b0, ZA},
    '{1'b0, 3'd0, 24'd0, '{16'sd0, 16'sd0, 16'sd0, 16'h7fff, 16'h8000, 16'h7fff}, 1'b0, ZA},
    '{1'b1, REG_UNUSED_LO, 24'hffffff, ZS, 1'b0, ZA},
    '{1'b1, REG_UNUSED_HI, 24'hffffff, ZS, 1'b0, ZA},
    '{1'b1, REG_GYRO_RANGE, 24'd3, ZS, 1'b0, ZA},
    '{1'b1, REG_SAMPLE_PERIOD, 24'hffffff, ZS, 1'b0, ZA},
    '{1'b1, REG_GYRO_OFFSET_X, 24'h007fff, ZS, 1'b0, ZA},
    '{1'b1, REG_GYRO_OFFSET_Y, 24'h008000, ZS, 1'b0, ZA},
    '{1'b1, REG_GYRO_OFFSET_Z, 24'h008000, ZS, 1'b0, ZA},
    '{1'b1, REG_BLEND_WEIGHT, 24'h00ffff, ZS, 1'b0, ZA},
    '{1'b0, 3'd0, 24'd0, '{16'sd0, 16'sd0, 16'sd0, 16'h8000, 16'h7fff, 16'h7fff}, 1'b0, ZA},
    '{1'b0, 3'd0, 24'd0, '{16'sd0, 16'sd0, 16'sd0, 16'h8000, 16'h7fff, 16'h7fff}, 1'b0, ZA},
    '{1'b0, 3'd0, 24'd0, '{16'sd0, 16'sd0, 16'sd0, 16'h8000, 16'h7fff, 16'h7fff}, 1'b0, ZA},
    '{1'b0, 3'd0, 24'd0, '{16'sd0, 16'sd0, 16'sd0, 16'h8000, 16'h7fff, 16'h7fff}, 1'b0, ZA},
    '{1'b0, 3'd0, 24'd0, '{16'sd0, 16'sd0, 16'sd0, 16'h8000, 16'h7fff, 16'h7fff}, 1'b0, ZA},
    '{1'b0, 3'd0, 24'd0, '{16'sd0, 16'sd0, 16'sd0, 16'h8000, 16'h7fff, 16'h7fff}, 1'b0, ZA},
    '{1'b0, 3'd0, 24'd0, '{16'sd0, 16'sd0, 16'sd0, 16'h8000, 16'h7fff, 16'h7fff}, 1'b0, ZA},
    '{1'b0, 3'd0, 24'd0, '{16'sd0, 16'sd0, 16'sd0, 16'h8000, 16'h7fff, 16'h7fff}, 1'b0, ZA},
    '{1'b1, REG_BLEND_WEIGHT, 24'd0, ZS, 1'b0, ZA},
    '{1'b0, 3'd0, 24'd0, '{16'sd9, -16'sd3000, -16'sd4000, 16'sd5, 16'sd5, 16'sd5}, 1'b0, ZA}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] accel_x = '0, accel_y = '0, accel_z = '0;
  logic signed [15:0] gyro_x = '0, gyro_y = '0, gyro_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] roll_deg, pitch_deg, yaw_deg;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [23:0] cfg_data = '0;

  logic [1:0] m_range;
  longint m_off_x, m_off_y, m_off_z;
  logic [15:0] m_tau;
  logic [23:0] m_dt;
  logic signed [31:0] m_roll, m_pitch, m_yaw;

  attitude_t attitude_q[$];
  int errors = 0;
  bit quiet = 1'b0;
  int stall_left = 0;

  imu_complementary_attitude i_dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic signed [31:0] sat32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint rate_step(longint g);
    longint unsigned mag, q, den, r;
    mag = (g < 0) ? -g : g;
    q = mag * longint'(m_dt) * 10;
    den = SENS_X10[m_range] << (TABLE_FRAC - ANGLE_FRACTION_BITS);
    r = (q + den / 2) / den;
    return (g < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint tilt_angle(longint y, longint x);
    longint z, t, xs, ys;
    int sh;
    z = 0;
    if (x == 0 && y == 0) return 0;
    x = x * 16384;
    y = y * 16384;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = 64'sd90 <<< TABLE_FRAC;
      end else begin
        x = -y; y = t; z = -(64'sd90 <<< TABLE_FRAC);
      end
    end
    for (int i = 0; i < NSTEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + ATAN_Q24[i];
      end else begin
        x = x - ys; y = y + xs; z = z - ATAN_Q24[i];
      end
    end
    sh = TABLE_FRAC - ANGLE_FRACTION_BITS;
    if (sh == 0) return z;
    return (z + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  function automatic logic signed [31:0] mix(longint prop, longint acc);
    longint w;
    w = longint'(m_tau);
    return sat32((w * prop + (65536 - w) * acc + 32768) >>> 16);
  endfunction

  function automatic attitude_t update_attitude(imu_sample_t s);
    longint dx, dy, dz;
    attitude_t a;
    dx = rate_step(longint'(s.gx) - m_off_x);
    dy = rate_step(longint'(s.gy) - m_off_y);
    dz = rate_step(longint'(s.gz) - m_off_z);
    m_roll = mix(longint'(m_roll) - dy, tilt_angle(s.ax, s.az));
    m_pitch = mix(longint'(m_pitch) + dx, tilt_angle(s.ay, s.az));
    m_yaw = sat32(longint'(m_yaw) + dz);
    a.roll = m_roll;
    a.pitch = m_pitch;
    a.yaw = m_yaw;
    return a;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0d want %0d at %0t", what, $signed(got), $signed(want), $time);
    errors++;
  endtask

  // random receiver stalls in bursts
  always @(posedge clk) begin
    if (quiet) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= (stall_left == 1);
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 3);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    attitude_t w;
    if (!rst && out_valid && out_ready) begin
      if (attitude_q.size() == 0) begin
        $display("unexpected output beat at %0t", $time);
        errors++;
      end else begin
        w = attitude_q.pop_front();
        if (roll_deg !== w.roll) report("roll", roll_deg, w.roll);
        if (pitch_deg !== w.pitch) report("pitch", pitch_deg, w.pitch);
        if (yaw_deg !== w.yaw) report("yaw", yaw_deg, w.yaw);
      end
    end
  end

  task automatic drain();
    in_valid <= 1'b0;
    while (attitude_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [23:0] data);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_GYRO_RANGE: m_range = data[1:0];
      REG_GYRO_OFFSET_X: m_off_x = longint'($signed(data[15:0]));
      REG_GYRO_OFFSET_Y: m_off_y = longint'($signed(data[15:0]));
      REG_GYRO_OFFSET_Z: m_off_z = longint'($signed(data[15:0]));
      REG_BLEND_WEIGHT: m_tau = data[15:0];
      REG_SAMPLE_PERIOD: m_dt = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_sample(imu_sample_t s, bit chk, attitude_t want);
    attitude_t a;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    {accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z} <= s;
    do @(posedge clk); while (!in_ready);
    a = update_attitude(s);
    if (chk && a !== want) begin
      $display("predictor disagrees with table row at %0t", $time);
      errors++;
    end
    attitude_q.push_back(chk ? want : a);
  endtask

  function automatic logic [15:0] raw_field(logic [15:0] near);
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return near + 16'($urandom_range(0, 4)) - 16'd2;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [23:0] pick_reg(logic [2:0] idx);
    bit hi;
    hi = $urandom_range(0, 1);
    case (idx)
      REG_GYRO_RANGE: return 24'($urandom_range(0, 3));
      REG_BLEND_WEIGHT: begin
        if ($urandom_range(0, 2) == 0) return hi ? 24'h00ffff : 24'd0;
        return 24'($urandom_range(60000, 65535));
      end
      REG_SAMPLE_PERIOD: begin
        if ($urandom_range(0, 2) == 0) return hi ? 24'hffffff : 24'd0;
        return 24'($urandom_range(1, 200000));
      end
      default: begin
        if ($urandom_range(0, 3) == 0) return hi ? 24'h007fff : 24'h008000;
        return {8'd0, 16'($signed(8'($urandom)))};
      end
    endcase
  endfunction

  initial begin
    imu_sample_t s;
    m_range = 0; m_off_x = 0; m_off_y = 0; m_off_z = 0;
    m_tau = 16'd64225; m_dt = 24'd67109;
    m_roll = 0; m_pitch = 0; m_yaw = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIR_TAB[k]) begin
      if (DIR_TAB[k].is_cfg) write_reg(DIR_TAB[k].idx, DIR_TAB[k].data);
      else send_sample(DIR_TAB[k].s, DIR_TAB[k].chk, DIR_TAB[k].want);
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      for (int r = 0; r <= int'(REG_SAMPLE_PERIOD); r++)
        if ($urandom_range(0, 1) == 0 || ph == 0) write_reg(3'(r), pick_reg(3'(r)));
      if (ph == RAND_PHASES - 1) quiet = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        s.ax = raw_field(16'd0);
        s.ay = raw_field(16'd0);
        s.az = raw_field(16'd0);
        if ($urandom_range(0, 19) == 0) begin
          s.ax = '0; s.ay = '0; s.az = '0;
        end
        s.gx = raw_field(m_off_x[15:0]);
        s.gy = raw_field(m_off_y[15:0]);
        s.gz = raw_field(m_off_z[15:0]);
        send_sample(s, 1'b0, ZA);
      end
    end

    drain();
    repeat (300) @(posedge clk);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #3000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
